[src/skl_pkg.sv]
// Shared types, codes and keyword table for the streaming keyword lexer.
package skl_pkg;

  localparam int MAX_TEXT_CHARS_DEF = 8;
  localparam int POS_BITS_DEF       = 16;
  localparam int RQ_DEPTH           = 4;

  localparam int MODE_W = 4;
  localparam int KIND_W = 5;
  localparam int KW_COUNT = 12;

  // scan modes
  localparam logic [MODE_W-1:0] M_IDLE  = 4'd0;
  localparam logic [MODE_W-1:0] M_IDENT = 4'd1;
  localparam logic [MODE_W-1:0] M_NUM   = 4'd2;
  localparam logic [MODE_W-1:0] M_LCOM  = 4'd3;
  localparam logic [MODE_W-1:0] M_BCOM  = 4'd4;
  localparam logic [MODE_W-1:0] M_BSTAR = 4'd5;
  localparam logic [MODE_W-1:0] M_SLASH = 4'd6;
  localparam logic [MODE_W-1:0] M_EQ    = 4'd7;
  localparam logic [MODE_W-1:0] M_BANG  = 4'd8;
  localparam logic [MODE_W-1:0] M_LT    = 4'd9;
  localparam logic [MODE_W-1:0] M_GT    = 4'd10;
  localparam logic [MODE_W-1:0] M_FCHAR = 4'd11;
  localparam logic [MODE_W-1:0] M_FBANG = 4'd12;

  // token kinds
  localparam logic [KIND_W-1:0] K_BYE   = 5'd0;
  localparam logic [KIND_W-1:0] K_GIMME = 5'd1;
  localparam logic [KIND_W-1:0] K_BOOL  = 5'd2;
  localparam logic [KIND_W-1:0] K_MAYBE = 5'd3;
  localparam logic [KIND_W-1:0] K_BUT   = 5'd4;
  localparam logic [KIND_W-1:0] K_NAH   = 5'd5;
  localparam logic [KIND_W-1:0] K_AND   = 5'd6;
  localparam logic [KIND_W-1:0] K_OR    = 5'd7;
  localparam logic [KIND_W-1:0] K_BAND  = 5'd8;
  localparam logic [KIND_W-1:0] K_BOR   = 5'd9;
  localparam logic [KIND_W-1:0] K_XOR   = 5'd10;
  localparam logic [KIND_W-1:0] K_IDENT = 5'd11;
  localparam logic [KIND_W-1:0] K_INT   = 5'd12;
  localparam logic [KIND_W-1:0] K_LPAR  = 5'd13;
  localparam logic [KIND_W-1:0] K_RPAR  = 5'd14;
  localparam logic [KIND_W-1:0] K_SEMI  = 5'd15;
  localparam logic [KIND_W-1:0] K_EQ    = 5'd16;
  localparam logic [KIND_W-1:0] K_EQEQ  = 5'd17;
  localparam logic [KIND_W-1:0] K_NEQ   = 5'd18;
  localparam logic [KIND_W-1:0] K_GE    = 5'd19;
  localparam logic [KIND_W-1:0] K_GT    = 5'd20;
  localparam logic [KIND_W-1:0] K_LE    = 5'd21;
  localparam logic [KIND_W-1:0] K_LT    = 5'd22;
  localparam logic [KIND_W-1:0] K_PLUS  = 5'd23;
  localparam logic [KIND_W-1:0] K_MINUS = 5'd24;
  localparam logic [KIND_W-1:0] K_STAR  = 5'd25;
  localparam logic [KIND_W-1:0] K_SLASH = 5'd26;
  localparam logic [KIND_W-1:0] K_LCUR  = 5'd27;
  localparam logic [KIND_W-1:0] K_RCUR  = 5'd28;

  // fault codes
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_CHAR = 2'd1;
  localparam logic [1:0] FAULT_BANG = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       source_end;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [15:0]       line_no;
    logic [15:0]       col_no;
    logic [63:0]       text;
    logic [7:0]        text_length;
    logic              truncated;
    logic [1:0]        fault;
    logic              run_end;
  } out_item_t;

  // results of one step, in order; cnt is 0, 1 or 2
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  typedef struct packed {
    logic [63:0]       word;
    logic [7:0]        len;
    logic [KIND_W-1:0] kind;
    logic [7:0]        tchar;
  } kw_entry_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
    logic [7:0]        tchar;
  } kw_hit_t;

  // words packed first character in the low byte
  localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
    '{64'h0000_0000_0065_7962, 8'd3, K_BYE,   8'h00},
    '{64'h0000_0065_6d6d_6967, 8'd5, K_GIMME, 8'h00},
    '{64'h0000_0000_0070_6579, 8'd3, K_BOOL,  8'h31},
    '{64'h0000_0000_6570_6f6e, 8'd4, K_BOOL,  8'h30},
    '{64'h0000_0065_6279_616d, 8'd5, K_MAYBE, 8'h00},
    '{64'h0000_0000_0074_7562, 8'd3, K_BUT,   8'h00},
    '{64'h0000_0000_0068_616e, 8'd3, K_NAH,   8'h00},
    '{64'h0000_0000_0064_6e61, 8'd3, K_AND,   8'h00},
    '{64'h0000_0000_0000_726f, 8'd2, K_OR,    8'h00},
    '{64'h0000_0000_646e_6162, 8'd4, K_BAND,  8'h00},
    '{64'h0000_0000_0072_6f62, 8'd3, K_BOR,   8'h00},
    '{64'h0000_0000_0072_6f78, 8'd3, K_XOR,   8'h00}
  };

  function automatic kw_hit_t kw_lookup(input logic [63:0] word, input logic [7:0] len);
    kw_hit_t h;
    h = '0;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (KW_TABLE[i].word == word && KW_TABLE[i].len == len) begin
        h.hit   = 1'b1;
        h.kind  = KW_TABLE[i].kind;
        h.tchar = KW_TABLE[i].tchar;
      end
    end
    return h;
  endfunction

endpackage

[src/skl_core.sv]
// Scanner state and the combinational step logic for one character.
module skl_core #(
  parameter int MAX_TEXT_CHARS = skl_pkg::MAX_TEXT_CHARS_DEF,
  parameter int POS_BITS       = skl_pkg::POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  skl_pkg::in_item_t item,
  output skl_pkg::push_t    push
);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [7:0]          CH_LF   = 8'h0A;
  localparam logic [7:0]          TXT_MAX = 8'(MAX_TEXT_CHARS);

  logic [skl_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [63:0]                buf_r, buf_nxt;
  logic [7:0]                 len_r, len_nxt;
  logic [POS_BITS-1:0]        line_r, line_nxt;
  logic [POS_BITS-1:0]        col_r, col_nxt;
  logic [POS_BITS-1:0]        adv_line, adv_col;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0d]};
  endfunction

  function automatic skl_pkg::out_item_t mk_res(
    input logic [skl_pkg::KIND_W-1:0] kind,
    input logic [POS_BITS-1:0]        ln,
    input logic [POS_BITS-1:0]        cl,
    input logic [63:0]                text,
    input logic [7:0]                 len,
    input logic [1:0]                 fault
  );
    skl_pkg::out_item_t r;
    r.kind        = kind;
    r.line_no     = 16'(ln);
    r.col_no      = 16'(cl);
    r.text        = text;
    r.text_length = len;
    r.truncated   = (len > TXT_MAX);
    r.fault       = fault;
    r.run_end     = 1'b0;
    return r;
  endfunction

  function automatic skl_pkg::out_item_t mk_word(
    input logic [63:0]         word,
    input logic [7:0]          len,
    input logic                number,
    input logic [POS_BITS-1:0] ln,
    input logic [POS_BITS-1:0] cl
  );
    skl_pkg::kw_hit_t h;
    h = skl_pkg::kw_lookup(word, len);
    if (number) begin
      return mk_res(skl_pkg::K_INT, ln, cl, word, len, skl_pkg::FAULT_NONE);
    end else if (h.hit) begin
      return mk_res(h.kind, ln, cl, 64'(h.tchar), (h.tchar != 8'h00) ? 8'd1 : 8'd0,
                    skl_pkg::FAULT_NONE);
    end
    return mk_res(skl_pkg::K_IDENT, ln, cl, word, len, skl_pkg::FAULT_NONE);
  endfunction

  // counters as they stand once this character is counted
  always_comb begin
    adv_line = line_r;
    adv_col  = col_r;
    if (item.char_in == CH_LF) begin
      if (line_r != POS_MAX) adv_line = line_r + POS_ONE;
      adv_col = POS_ONE;
    end else if (col_r != POS_MAX) begin
      adv_col = col_r + POS_ONE;
    end
  end

  always_comb begin
    logic [7:0]                 c;
    logic                       adv, done, halted, flt_vld;
    logic                       p1_vld, p2_vld, p3_vld;
    logic [skl_pkg::MODE_W-1:0] m;
    logic [skl_pkg::KIND_W-1:0] sk;
    logic                       sk_vld;
    logic [POS_BITS-1:0]        post_line, post_col;
    logic [1:0]                 cnt;
    skl_pkg::out_item_t         p1, p2, p3, pf;
    skl_pkg::out_item_t         slot [2];

    c        = item.char_in;
    adv      = 1'b0;
    done     = 1'b0;
    flt_vld  = 1'b0;
    p1_vld   = 1'b0;
    p2_vld   = 1'b0;
    p3_vld   = 1'b0;
    p1       = '0;
    p2       = '0;
    p3       = '0;
    pf       = '0;
    mode_nxt = mode_r;
    buf_nxt  = buf_r;
    len_nxt  = len_r;
    m        = mode_r;
    halted   = (mode_r == skl_pkg::M_FCHAR) || (mode_r == skl_pkg::M_FBANG);

    sk_vld = 1'b1;
    case (c)
      "(":     sk = skl_pkg::K_LPAR;
      ")":     sk = skl_pkg::K_RPAR;
      ";":     sk = skl_pkg::K_SEMI;
      "+":     sk = skl_pkg::K_PLUS;
      "-":     sk = skl_pkg::K_MINUS;
      "*":     sk = skl_pkg::K_STAR;
      "{":     sk = skl_pkg::K_LCUR;
      "}":     sk = skl_pkg::K_RCUR;
      default: begin
        sk     = skl_pkg::K_BYE;
        sk_vld = 1'b0;
      end
    endcase

    if (halted) begin
      flt_vld = 1'b1;
      pf = mk_res(skl_pkg::K_BYE, line_r, col_r, 64'd0, 8'd0,
                  (mode_r == skl_pkg::M_FCHAR) ? skl_pkg::FAULT_CHAR : skl_pkg::FAULT_BANG);
    end else begin
      // close or continue whatever the previous character left open
      case (mode_r)
        skl_pkg::M_IDENT, skl_pkg::M_NUM: begin
          if (mode_r == skl_pkg::M_IDENT ? (is_alpha(c) || is_digit(c)) : is_digit(c)) begin
            if (len_r < TXT_MAX) buf_nxt = buf_r | (64'(c) << {len_r[2:0], 3'b000});
            if (len_r != 8'hFF) len_nxt = len_r + 8'd1;
            adv  = 1'b1;
            done = 1'b1;
          end else begin
            p1_vld   = 1'b1;
            p1       = mk_word(buf_r, len_r, mode_r == skl_pkg::M_NUM, line_r, col_r);
            mode_nxt = skl_pkg::M_IDLE;
          end
        end
        skl_pkg::M_LCOM: begin
          if (c == CH_LF) begin
            mode_nxt = skl_pkg::M_IDLE;
          end else begin
            adv  = 1'b1;
            done = 1'b1;
          end
        end
        skl_pkg::M_BCOM: begin
          if (c == "*") mode_nxt = skl_pkg::M_BSTAR;
          adv  = 1'b1;
          done = 1'b1;
        end
        skl_pkg::M_BSTAR: begin
          if (c == "/") mode_nxt = skl_pkg::M_IDLE;
          else if (c != "*") mode_nxt = skl_pkg::M_BCOM;
          adv  = 1'b1;
          done = 1'b1;
        end
        skl_pkg::M_SLASH: begin
          if (c == "/") begin
            mode_nxt = skl_pkg::M_LCOM;
            adv      = 1'b1;
            done     = 1'b1;
          end else if (c == "*") begin
            mode_nxt = skl_pkg::M_BCOM;
            adv      = 1'b1;
            done     = 1'b1;
          end else begin
            p1_vld   = 1'b1;
            p1       = mk_res(skl_pkg::K_SLASH, line_r, col_r, 64'd0, 8'd0,
                              skl_pkg::FAULT_NONE);
            mode_nxt = skl_pkg::M_IDLE;
          end
        end
        skl_pkg::M_EQ, skl_pkg::M_BANG, skl_pkg::M_LT, skl_pkg::M_GT: begin
          mode_nxt = skl_pkg::M_IDLE;
          if (c == "=") begin
            adv    = 1'b1;
            done   = 1'b1;
            p1_vld = 1'b1;
            p1 = mk_res((m == skl_pkg::M_EQ)   ? skl_pkg::K_EQEQ :
                        (m == skl_pkg::M_BANG) ? skl_pkg::K_NEQ  :
                        (m == skl_pkg::M_LT)   ? skl_pkg::K_LE   : skl_pkg::K_GE,
                        adv_line, adv_col, 64'd0, 8'd0, skl_pkg::FAULT_NONE);
          end else if (m == skl_pkg::M_BANG) begin
            flt_vld  = 1'b1;
            pf       = mk_res(skl_pkg::K_BYE, line_r, col_r, 64'd0, 8'd0,
                              skl_pkg::FAULT_BANG);
            mode_nxt = skl_pkg::M_FBANG;
          end else begin
            p1_vld = 1'b1;
            p1 = mk_res((m == skl_pkg::M_EQ) ? skl_pkg::K_EQ :
                        (m == skl_pkg::M_LT) ? skl_pkg::K_LT : skl_pkg::K_GT,
                        line_r, col_r, 64'd0, 8'd0, skl_pkg::FAULT_NONE);
          end
        end
        default: mode_nxt = skl_pkg::M_IDLE;
      endcase

      // start a new token from this character
      if (!done && !flt_vld) begin
        if (is_alpha(c) || is_digit(c)) begin
          buf_nxt  = 64'(c);
          len_nxt  = 8'd1;
          mode_nxt = is_alpha(c) ? skl_pkg::M_IDENT : skl_pkg::M_NUM;
          adv      = 1'b1;
        end else if (c == "/") begin
          mode_nxt = skl_pkg::M_SLASH;
          adv      = 1'b1;
        end else if (c == "=") begin
          mode_nxt = skl_pkg::M_EQ;
          adv      = 1'b1;
        end else if (c == "!") begin
          mode_nxt = skl_pkg::M_BANG;
          adv      = 1'b1;
        end else if (c == "<") begin
          mode_nxt = skl_pkg::M_LT;
          adv      = 1'b1;
        end else if (c == ">") begin
          mode_nxt = skl_pkg::M_GT;
          adv      = 1'b1;
        end else if (sk_vld) begin
          adv    = 1'b1;
          p2_vld = 1'b1;
          p2     = mk_res(sk, adv_line, adv_col, 64'd0, 8'd0, skl_pkg::FAULT_NONE);
        end else if (is_space(c)) begin
          adv = 1'b1;
        end else begin
          flt_vld  = 1'b1;
          pf       = mk_res(skl_pkg::K_BYE, line_r, col_r, 64'd0, 8'd0,
                            skl_pkg::FAULT_CHAR);
          mode_nxt = skl_pkg::M_FCHAR;
        end
      end
    end

    post_line = adv ? adv_line : line_r;
    post_col  = adv ? adv_col  : col_r;
    line_nxt  = post_line;
    col_nxt   = post_col;

    // flush at end of source, then restart the counters; a pending '!' faults instead
    if (!halted && !flt_vld && item.source_end) begin
      case (mode_nxt)
        skl_pkg::M_IDENT: begin
          p3_vld = 1'b1;
          p3     = mk_word(buf_nxt, len_nxt, 1'b0, post_line, post_col);
        end
        skl_pkg::M_NUM: begin
          p3_vld = 1'b1;
          p3     = mk_word(buf_nxt, len_nxt, 1'b1, post_line, post_col);
        end
        skl_pkg::M_SLASH, skl_pkg::M_EQ, skl_pkg::M_LT, skl_pkg::M_GT: begin
          p3_vld = 1'b1;
          p3 = mk_res((mode_nxt == skl_pkg::M_SLASH) ? skl_pkg::K_SLASH :
                      (mode_nxt == skl_pkg::M_EQ)    ? skl_pkg::K_EQ    :
                      (mode_nxt == skl_pkg::M_LT)    ? skl_pkg::K_LT    : skl_pkg::K_GT,
                      post_line, post_col, 64'd0, 8'd0, skl_pkg::FAULT_NONE);
        end
        skl_pkg::M_BANG: begin
          flt_vld = 1'b1;
          pf      = mk_res(skl_pkg::K_BYE, post_line, post_col, 64'd0, 8'd0,
                           skl_pkg::FAULT_BANG);
        end
        default: ;
      endcase
      if (mode_nxt == skl_pkg::M_BANG) begin
        mode_nxt = skl_pkg::M_FBANG;
      end else begin
        mode_nxt = skl_pkg::M_IDLE;
        buf_nxt  = 64'd0;
        len_nxt  = 8'd0;
        line_nxt = POS_ONE;
        col_nxt  = POS_ONE;
      end
    end

    // pack the results in order and mark the last one
    cnt     = 2'd0;
    slot[0] = '0;
    slot[1] = '0;
    if (p1_vld) begin
      slot[cnt[0]] = p1;
      cnt = cnt + 2'd1;
    end
    if (p2_vld) begin
      slot[cnt[0]] = p2;
      cnt = cnt + 2'd1;
    end
    if (p3_vld) begin
      slot[cnt[0]] = p3;
      cnt = cnt + 2'd1;
    end
    if (flt_vld) begin
      slot[cnt[0]] = pf;
      cnt = cnt + 2'd1;
    end
    if (cnt == 2'd1) slot[0].run_end = 1'b1;
    if (cnt == 2'd2) slot[1].run_end = 1'b1;
    push.cnt = cnt;
    push.r0  = slot[0];
    push.r1  = slot[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= skl_pkg::M_IDLE;
      buf_r  <= 64'd0;
      len_r  <= 8'd0;
      line_r <= POS_ONE;
      col_r  <= POS_ONE;
    end else if (step) begin
      mode_r <= mode_nxt;
      buf_r  <= buf_nxt;
      len_r  <= len_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

[src/skl_fifo.sv]
// Result queue: takes up to two tokens per cycle, hands out one per transaction.
module skl_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_en,
  input  skl_pkg::push_t      push,
  input  logic                pop,
  output logic                head_vld,
  output skl_pkg::out_item_t  head,
  output logic                room2
);

  localparam int DEPTH = skl_pkg::RQ_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  skl_pkg::out_item_t q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         n_push;

  assign n_push   = push_en ? push.cnt : 2'd0;
  assign head_vld = (cnt_r != '0);
  assign head     = q[rd_ptr_r];
  assign room2    = (cnt_r <= CNT_W'(DEPTH - 2));
  assign cnt_nxt  = cnt_r + CNT_W'(n_push) - CNT_W'(pop && head_vld);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q[wr_ptr_r] <= push.r0;
    if (n_push == 2'd2) q[PTR_W'(wr_ptr_r + 1'b1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= PTR_W'(wr_ptr_r + PTR_W'(n_push));
      if (pop && head_vld) rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[src/streaming_keyword_lexer.sv]
// Streaming keyword lexer top level: input register, scanner step and result queue.
//
// Usage: feed source text on the in_ channel, one ASCII character per transaction,
// with source_end set on the last character of each source. Tokens come out on the
// out_ channel, one per transaction, in source order; each input character yields
// zero, one or two tokens, and run_end marks the last token a character produced.
// A token passes the input register, then the result queue, before it shows on
// out_valid, and it leaves while out_stall is low. A queue without room for two
// tokens holds the character that completes it in the input register.
// Throughput: one character per cycle while the output keeps pace. The scanner
// steps a character only when the four-entry result queue has room for two
// tokens, so characters that yield two tokens faster than the out_ channel drains
// them, or a stalled receiver, let the queue fill and in_stall rises until the
// head drains.
// Reset (rst_n low, synchronous): scanner returns to idle, counters to line 1
// column 1, the fault clears, queue and input register empty. A fault is sticky:
// every later character yields one fault token until reset.
// out_stall high holds the head token and its valid; input keeps being taken
// into the queue while it has room.
module streaming_keyword_lexer #(
  parameter int MAX_TEXT_CHARS = skl_pkg::MAX_TEXT_CHARS_DEF,
  parameter int POS_BITS       = skl_pkg::POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  skl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output skl_pkg::out_item_t  out_data
);

  logic              in_vld_r;
  skl_pkg::in_item_t in_item_r;
  logic              room2;
  logic              step;
  skl_pkg::push_t    push;

  // step the held character once the queue can absorb its worst case
  assign step     = in_vld_r && room2;
  assign in_stall = in_vld_r && !room2;

  // hold the accepted character; refill in the same cycle it steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_data;
  end

  skl_core #(
    .MAX_TEXT_CHARS (MAX_TEXT_CHARS),
    .POS_BITS       (POS_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .push  (push)
  );

  // drain one token per out transaction
  skl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (step),
    .push     (push),
    .pop      (!out_stall),
    .head_vld (out_valid),
    .head     (out_data),
    .room2    (room2)
  );

endmodule

[src/skl_checker.sv]
// Port-level checks for the streaming keyword lexer, bound to the top level.
module skl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input skl_pkg::out_item_t out_data
);

  // a stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("out token changed while stalled");

  // an empty result queue never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a fault token is always the last of its character
  a_fault_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault != skl_pkg::FAULT_NONE |-> out_data.run_end)
    else $error("fault token not marked as last");

  // after a fault only the same fault follows
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.fault != skl_pkg::FAULT_NONE
    |=> !out_valid || out_data.fault == $past(out_data.fault))
    else $error("fault did not persist");

endmodule

bind streaming_keyword_lexer skl_checker u_skl_checker (.*);

[bench/tb_streaming_keyword_lexer.sv]
// Testbench for streaming_keyword_lexer: random source text, token prediction and checking.
module tb_streaming_keyword_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  // Token scoreboard: tracks the lexer state character by character and
  // queues the tokens that each accepted character must produce.
  class token_scoreboard;
    string kw_spell [12] = '{"bye", "gimme", "yep", "nope", "maybe", "but",
                             "nah", "and", "or", "band", "bor", "xor"};
    logic [skl_pkg::KIND_W-1:0] kw_kind [12] = '{
      skl_pkg::K_BYE, skl_pkg::K_GIMME, skl_pkg::K_BOOL, skl_pkg::K_BOOL,
      skl_pkg::K_MAYBE, skl_pkg::K_BUT, skl_pkg::K_NAH, skl_pkg::K_AND,
      skl_pkg::K_OR, skl_pkg::K_BAND, skl_pkg::K_BOR, skl_pkg::K_XOR};
    logic [7:0] kw_text [12] = '{8'h00, 8'h00, "1", "0", 8'h00, 8'h00,
                                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

    logic [skl_pkg::MODE_W-1:0] mode;
    logic [63:0]                wbuf;
    logic [7:0]                 wlen;
    logic [15:0]                line_cnt;
    logic [15:0]                col_cnt;
    bit                         halted;

    skl_pkg::out_item_t step_tokens[$];
    skl_pkg::out_item_t expected_tokens[$];
    int        chars_seen;
    int        tokens_checked;
    int        failures;
    bit        kind_seen [32];

    function new();
      mode     = skl_pkg::M_IDLE;
      wbuf     = '0;
      wlen     = '0;
      line_cnt = 16'd1;
      col_cnt  = 16'd1;
      halted   = 1'b0;
    endfunction

    static function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    static function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    static function bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    static function bit punct_kind(input logic [7:0] c,
                                   output logic [skl_pkg::KIND_W-1:0] k);
      k = skl_pkg::K_LPAR;
      case (c)
        "(": k = skl_pkg::K_LPAR;
        ")": k = skl_pkg::K_RPAR;
        ";": k = skl_pkg::K_SEMI;
        "+": k = skl_pkg::K_PLUS;
        "-": k = skl_pkg::K_MINUS;
        "*": k = skl_pkg::K_STAR;
        "{": k = skl_pkg::K_LCUR;
        "}": k = skl_pkg::K_RCUR;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    static function bit starts_token(logic [7:0] c);
      logic [skl_pkg::KIND_W-1:0] k;
      return is_letter(c) || is_digit(c) || c == "/" || c == "=" || c == "!" ||
             c == "<" || c == ">" || punct_kind(c, k);
    endfunction

    // A newline moves to the next line; anything else moves one column. Both saturate.
    function void bump(logic [7:0] c);
      if (c == 8'h0A) begin
        if (line_cnt != 16'hFFFF) line_cnt++;
        col_cnt = 16'd1;
      end else if (col_cnt != 16'hFFFF) begin
        col_cnt++;
      end
    endfunction

    function void add_token(logic [skl_pkg::KIND_W-1:0] kind, logic [63:0] text,
                            logic [7:0] len, logic [1:0] fault);
      skl_pkg::out_item_t t;
      if (step_tokens.size() >= 2) return;
      t.kind        = kind;
      t.line_no     = line_cnt;
      t.col_no      = col_cnt;
      t.text        = text;
      t.text_length = len;
      t.truncated   = len > skl_pkg::MAX_TEXT_CHARS_DEF;
      t.fault       = fault;
      t.run_end     = 1'b0;
      step_tokens   = {step_tokens, t};
    endfunction

    function void append_char(logic [7:0] c);
      if (wlen < skl_pkg::MAX_TEXT_CHARS_DEF) wbuf[8*wlen +: 8] = c;
      if (wlen != 8'hFF) wlen++;
    endfunction

    function void flush_word(bit number);
      bit same;
      if (number) begin
        add_token(skl_pkg::K_INT, wbuf, wlen, skl_pkg::FAULT_NONE);
        return;
      end
      for (int i = 0; i < 12; i++) begin
        same = (wlen == kw_spell[i].len());
        for (int j = 0; same && j < kw_spell[i].len(); j++)
          if (wbuf[8*j +: 8] != kw_spell[i][j]) same = 1'b0;
        if (same) begin
          add_token(kw_kind[i], {56'b0, kw_text[i]}, (kw_text[i] != 8'h00) ? 8'd1 : 8'd0,
                    skl_pkg::FAULT_NONE);
          return;
        end
      end
      add_token(skl_pkg::K_IDENT, wbuf, wlen, skl_pkg::FAULT_NONE);
    endfunction

    // Fault tokens carry kind zero and an empty text.
    function void raise_fault(logic [1:0] code);
      halted = 1'b1;
      mode   = (code == skl_pkg::FAULT_CHAR) ? skl_pkg::M_FCHAR : skl_pkg::M_FBANG;
      add_token(skl_pkg::K_BYE, '0, 8'd0, code);
    endfunction

    function void close_step();
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].run_end = 1'b1;
      foreach (step_tokens[i]) expected_tokens = {expected_tokens, step_tokens[i]};
    endfunction

    // Advance the lexer by one accepted character and queue its tokens.
    function void note_char(logic [7:0] c, logic last);
      bit                         done;
      logic [skl_pkg::MODE_W-1:0] held;
      logic [skl_pkg::KIND_W-1:0] pk;
      done = 1'b0;
      chars_seen++;
      step_tokens.delete();
      if (halted) begin
        add_token(skl_pkg::K_BYE, '0, 8'd0,
                  (mode == skl_pkg::M_FCHAR) ? skl_pkg::FAULT_CHAR : skl_pkg::FAULT_BANG);
        close_step();
        return;
      end
      case (mode)
        skl_pkg::M_IDENT, skl_pkg::M_NUM: begin
          if (mode == skl_pkg::M_IDENT ? (is_letter(c) || is_digit(c)) : is_digit(c)) begin
            append_char(c);
            bump(c);
            done = 1'b1;
          end else begin
            flush_word(mode == skl_pkg::M_NUM);
            mode = skl_pkg::M_IDLE;
          end
        end
        skl_pkg::M_LCOM: begin
          if (c == 8'h0A) mode = skl_pkg::M_IDLE;
          else begin
            bump(c);
            done = 1'b1;
          end
        end
        skl_pkg::M_BCOM: begin
          if (c == "*") mode = skl_pkg::M_BSTAR;
          bump(c);
          done = 1'b1;
        end
        skl_pkg::M_BSTAR: begin
          if (c == "/") mode = skl_pkg::M_IDLE;
          else if (c != "*") mode = skl_pkg::M_BCOM;
          bump(c);
          done = 1'b1;
        end
        skl_pkg::M_SLASH: begin
          if (c == "/") begin
            mode = skl_pkg::M_LCOM;
            bump(c);
            done = 1'b1;
          end else if (c == "*") begin
            mode = skl_pkg::M_BCOM;
            bump(c);
            done = 1'b1;
          end else begin
            add_token(skl_pkg::K_SLASH, '0, 8'd0, skl_pkg::FAULT_NONE);
            mode = skl_pkg::M_IDLE;
          end
        end
        skl_pkg::M_EQ, skl_pkg::M_BANG, skl_pkg::M_LT, skl_pkg::M_GT: begin
          held = mode;
          mode = skl_pkg::M_IDLE;
          if (c == "=") begin
            bump(c);
            done = 1'b1;
            add_token(held == skl_pkg::M_EQ   ? skl_pkg::K_EQEQ :
                      held == skl_pkg::M_BANG ? skl_pkg::K_NEQ  :
                      held == skl_pkg::M_LT   ? skl_pkg::K_LE   : skl_pkg::K_GE,
                      '0, 8'd0, skl_pkg::FAULT_NONE);
          end else if (held == skl_pkg::M_BANG) begin
            raise_fault(skl_pkg::FAULT_BANG);
            close_step();
            return;
          end else begin
            add_token(held == skl_pkg::M_EQ ? skl_pkg::K_EQ :
                      held == skl_pkg::M_LT ? skl_pkg::K_LT : skl_pkg::K_GT,
                      '0, 8'd0, skl_pkg::FAULT_NONE);
          end
        end
        default: mode = skl_pkg::M_IDLE;
      endcase

      if (!done) begin
        if (is_letter(c)) begin
          wbuf = {56'b0, c};
          wlen = 8'd1;
          mode = skl_pkg::M_IDENT;
          bump(c);
        end else if (is_digit(c)) begin
          wbuf = {56'b0, c};
          wlen = 8'd1;
          mode = skl_pkg::M_NUM;
          bump(c);
        end else if (c == "/") begin
          mode = skl_pkg::M_SLASH;
          bump(c);
        end else if (c == "=") begin
          mode = skl_pkg::M_EQ;
          bump(c);
        end else if (c == "!") begin
          mode = skl_pkg::M_BANG;
          bump(c);
        end else if (c == "<") begin
          mode = skl_pkg::M_LT;
          bump(c);
        end else if (c == ">") begin
          mode = skl_pkg::M_GT;
          bump(c);
        end else if (punct_kind(c, pk)) begin
          bump(c);
          add_token(pk, '0, 8'd0, skl_pkg::FAULT_NONE);
        end else if (is_blank(c)) begin
          bump(c);
        end else begin
          raise_fault(skl_pkg::FAULT_CHAR);
          close_step();
          return;
        end
      end

      // Source end: flush whatever is pending, drop open comments, restart at 1:1 (a pending '!' faults instead).
      if (last) begin
        case (mode)
          skl_pkg::M_IDENT: flush_word(1'b0);
          skl_pkg::M_NUM:   flush_word(1'b1);
          skl_pkg::M_SLASH: add_token(skl_pkg::K_SLASH, '0, 8'd0, skl_pkg::FAULT_NONE);
          skl_pkg::M_EQ:    add_token(skl_pkg::K_EQ, '0, 8'd0, skl_pkg::FAULT_NONE);
          skl_pkg::M_LT:    add_token(skl_pkg::K_LT, '0, 8'd0, skl_pkg::FAULT_NONE);
          skl_pkg::M_GT:    add_token(skl_pkg::K_GT, '0, 8'd0, skl_pkg::FAULT_NONE);
          skl_pkg::M_BANG: begin
            raise_fault(skl_pkg::FAULT_BANG);
            close_step();
            return;
          end
          default: ;
        endcase
        mode     = skl_pkg::M_IDLE;
        wbuf     = '0;
        wlen     = '0;
        line_cnt = 16'd1;
        col_cnt  = 16'd1;
      end
      close_step();
    endfunction

    function string show(skl_pkg::out_item_t t);
      return $sformatf("kind=%0d line=%0d col=%0d text=%h len=%0d trunc=%0b fault=%0d end=%0b",
                       t.kind, t.line_no, t.col_no, t.text, t.text_length, t.truncated,
                       t.fault, t.run_end);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_token(skl_pkg::out_item_t got);
      skl_pkg::out_item_t want;
      if (expected_tokens.size() == 0) begin
        note_failure($sformatf("token with none expected: %s", show(got)));
        return;
      end
      want = expected_tokens.pop_front();
      tokens_checked++;
      if (got.kind !== want.kind || got.line_no !== want.line_no ||
          got.col_no !== want.col_no || got.text !== want.text ||
          got.text_length !== want.text_length || got.truncated !== want.truncated ||
          got.fault !== want.fault || got.run_end !== want.run_end)
        note_failure($sformatf("token %0d mismatch\n  expected %s\n  actual   %s",
                               tokens_checked, show(want), show(got)));
      else if (want.fault == skl_pkg::FAULT_NONE)
        kind_seen[want.kind] = 1'b1;
    endfunction

    function void check_leftover();
      if (expected_tokens.size() != 0)
        note_failure($sformatf("%0d expected tokens never arrived", expected_tokens.size()));
    endfunction

    function int kinds_covered();
      int n;
      n = 0;
      foreach (kind_seen[i]) if (kind_seen[i]) n++;
      return n;
    endfunction
  endclass

  // Operator and bracket spellings used to build random source text.
  string op_spell [16] = '{"(", ")", ";", "=", "==", "!=", ">=", ">",
                           "<=", "<", "+", "-", "*", "/", "{", "}"};
  // Loose characters for noise: no '/' or '!', so no comment opens and no fault
  // starts by accident.
  string noise_set = "aZq7 \t();+-*{}=<>";

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  skl_pkg::in_item_t  in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  skl_pkg::out_item_t out_data;

  token_scoreboard sb = new();
  bit          idle_en;       // random idling on both channels
  int          stall_left;    // remaining cycles of the current output stall burst
  logic [7:0]  src_chars[$];  // source text being sent
  int          random_chars;
  int          src_no;
  int          fault_pick;

  streaming_keyword_lexer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall in bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 4);
    if (!idle_en) stall_left = 0;
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // Check every token transaction against the oldest expected token.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_token(out_data);
  end

  // Present one character and hold it until accepted. Enter and leave at a
  // falling edge; lower valid only for a gap, so it never drops and rises in
  // the same step.
  task automatic send_char(input logic [7:0] c, input logic last);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_in: c, source_end: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_char(c, last);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Hold the sender off until every expected token has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(48, 57));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter();
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 7))
      0: return 8'h09;
      1: return 8'h0A;
      2: return 8'h0B;
      3: return 8'h0C;
      4: return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  // Any byte that starts no token and is not whitespace.
  function automatic logic [7:0] bad_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (token_scoreboard::starts_token(b) || token_scoreboard::is_blank(b));
    return b;
  endfunction

  function automatic void put_char(logic [7:0] c);
    src_chars = {src_chars, c};
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  // Append one random token. The closing token of a source may leave a
  // comment open, which the block drops silently.
  function automatic void put_random_token(bit closing);
    int         n;
    int         r;
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0, 1: begin
        // keyword, sometimes one character long or short so it turns into an identifier
        put_text(sb.kw_spell[$urandom_range(0, 11)]);
        r = $urandom_range(0, 5);
        if (r == 0) put_char(rand_alnum());
        else if (r == 1) void'(src_chars.pop_back());
        if (src_chars.size() == 0) put_char(rand_letter());
      end
      2, 3: begin
        r = $urandom_range(0, 9);
        n = (r < 7) ? $urandom_range(1, 6) : (r < 9) ? $urandom_range(7, 10)
                                                      : $urandom_range(11, 20);
        put_char(rand_letter());
        repeat (n - 1) put_char(rand_alnum());
      end
      4: repeat ($urandom_range(1, 12)) put_char(rand_digit());
      5: begin
        // number running straight into letters: two tokens
        repeat ($urandom_range(1, 4)) put_char(rand_digit());
        repeat ($urandom_range(1, 4)) put_char(rand_letter());
      end
      6, 7: begin
        put_text(op_spell[$urandom_range(0, 15)]);
        // keep a slash from opening a comment with whatever follows
        if (src_chars[src_chars.size() - 1] == "/" && !closing)
          put_char(rand_blank());
      end
      8: begin
        put_text("//");
        repeat ($urandom_range(0, 8)) begin
          do b = 8'($urandom_range(0, 255)); while (b == 8'h0A);
          put_char(b);
        end
        if (!closing || $urandom_range(0, 1)) put_char(8'h0A);
      end
      9: begin
        put_text("/*");
        repeat ($urandom_range(0, 8)) begin
          do b = 8'($urandom_range(0, 255)); while (b == "/");
          put_char(b);
        end
        if (!closing || $urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 3)) put_char("*");
          put_char("/");
        end
      end
      10: repeat ($urandom_range(1, 3))
            put_char(noise_set[$urandom_range(0, noise_set.len() - 1)]);
      default: repeat ($urandom_range(1, 3)) put_char(rand_blank());
    endcase
  endfunction

  task automatic send_source();
    int ntok;
    src_chars.delete();
    ntok = $urandom_range(1, 10);
    for (int i = 0; i < ntok; i++) begin
      put_random_token(i == ntok - 1);
      if (i != ntok - 1 && $urandom_range(0, 1) == 0) put_char(rand_blank());
    end
    random_chars += src_chars.size();
    foreach (src_chars[i]) send_char(src_chars[i], i == src_chars.size() - 1);
  endtask

  initial begin
    idle_en = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: bool keywords around '<=', every bracket and one-character
    // operator, and the pending lookahead characters flushed at source end.
    idle_en = 1'b1;
    send_text("yep<=nope");
    send_text("(-5*x)>{+}/");
    send_text("=");
    send_text(">");
    send_text("<");

    // Make text longer than the length field can hold. Run this stretch
    // without idling.
    idle_en = 1'b0;
    send_char(rand_letter(), 1'b0);
    repeat (259) send_char(rand_alnum(), 1'b0);
    send_char(";", 1'b1);
    wait_drained();

    // Random sources with idling; drain once midway, go quiet near the end.
    idle_en = 1'b1;
    random_chars = 0;
    src_no = 0;
    while (random_chars < 200) begin
      if (random_chars >= 160) idle_en = 1'b0;
      send_source();
      src_no++;
      if (src_no == 4) wait_drained();
    end

    // Finish with a fault, since it sticks until reset, then show that every
    // further character, source end included, repeats it.
    idle_en = 1'b0;
    fault_pick = $urandom_range(0, 3);
    case (fault_pick)
      0: begin
        // identifier completed by the same character that faults
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_char(bad_byte(), 1'($urandom_range(0, 1)));
      end
      1: begin
        send_char("x", 1'b0);
        send_char("!", 1'b0);
        send_char("y", 1'b0);
      end
      2: begin
        send_char("(", 1'b0);
        send_char("!", 1'b1);
      end
      default: send_char(bad_byte(), 1'b0);
    endcase
    repeat (20) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    // Drop valid, wait out the remaining tokens, then allow the pipeline to settle.
    in_valid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    sb.check_leftover();

    $display("Summary: %0d characters in %0d random sources plus directed and saturation runs,",
             sb.chars_seen, src_no);
    $display("Summary: %0d tokens checked, %0d of 29 token kinds seen, fault scenario %0d",
             sb.tokens_checked, sb.kinds_covered(), fault_pick);
    if (sb.failures == 0) begin
      $display("PASS streaming_keyword_lexer");
    end else begin
      $display("FAIL streaming_keyword_lexer");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is a small fraction of this.
  initial begin
    #10ms;
    $display("FAIL streaming_keyword_lexer");
    $finish;
  end

endmodule
